FILE: rtl/pid_speed_regulator_unit_macros.svh
// Assertion macros for the speed regulator.
// Define ASSERT_OFF to compile every assertion away.
`ifndef PID_SPEED_REGULATOR_UNIT_MACROS_SVH
`define PID_SPEED_REGULATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PSR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("psr assertion failed");
`define PSR_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("psr forbidden condition seen");
`else
`define PSR_ASSERT(lbl, prop)
`define PSR_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/psr_pkg.sv
`timescale 1ns / 1ps

package psr_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int PWM_BITS_DEF    = 8;
   localparam int GAIN_W          = 16;
   localparam int FRAC_BITS       = 8;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 16'd4288;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 16'd0;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 16'd0;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN  = 2'd0,
      CSR_INTEG_GAIN = 2'd1,
      CSR_DERIV_GAIN = 2'd2
   } csr_index_type;

   // load: the stage register takes a new word this cycle
   // src_valid: the word offered by the stage upstream is real
   typedef struct packed {
      logic load;
      logic src_valid;
   } stage_ctl_type;

endpackage

FILE: rtl/pid_speed_regulator_unit.sv
`timescale 1ns / 1ps
// PID speed regulator, derivative taken on the measurement.
// Request channel (req_valid/req_ready): one word per sample tick, carrying
// the measured value and the setpoint. Response channel (rsp_valid/
// rsp_ready): one word per request, the clamped drive level and the PWM duty
// derived from it (drive * (2^PWM_BITS-1) / (2^SAMPLE_BITS-1), truncated).
// Gains are written through the csr_ port: index 0 proportional, 1 integral,
// 2 derivative, all unsigned Q8.8; index 3 is ignored. Write them only while
// no word is in flight.
// From request accept to response valid the word passes three registers: the
// input register takes it at the accept edge, then the control-law register
// (three gain multipliers, sum, clamp) and then the result register (constant
// scaling to the PWM range). Throughput is one word per cycle while the
// receiver does not stall, paced by the control-law stage, which also updates
// the integral and the last measurement in request order.
// Reset clears all pipeline valids, the integral and the last measurement,
// and loads the default gains. When the receiver stalls, the response word
// holds and the stages behind it keep filling; req_ready drops only once all
// three stages hold words.
`include "pid_speed_regulator_unit_macros.svh"

module pid_speed_regulator_unit #(
   parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF,
   parameter int PWM_BITS    = psr_pkg::PWM_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [SAMPLE_BITS-1:0]             req_measured,
   input  logic [SAMPLE_BITS-1:0]             req_target,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [SAMPLE_BITS-1:0]             rsp_drive_level,
   output logic [PWM_BITS-1:0]                rsp_pwm_duty,
   input  logic                               csr_write_en,
   input  logic [psr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [psr_pkg::GAIN_W-1:0]         csr_wdata
);

   // gain registers
   logic [psr_pkg::GAIN_W-1:0] prop_gain_ff;
   logic [psr_pkg::GAIN_W-1:0] integ_gain_ff;
   logic [psr_pkg::GAIN_W-1:0] deriv_gain_ff;

   // input stage
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] meas_ff;
   logic [SAMPLE_BITS-1:0] tgt_ff;

   // pipeline movement
   logic                   adv_in;
   logic                   adv_law;
   logic                   adv_out;
   logic                   drive_valid;
   logic [SAMPLE_BITS-1:0] drive_level;
   psr_pkg::stage_ctl_type law_ctl;
   psr_pkg::stage_ctl_type out_ctl;

   // Each stage advances when it is empty or the stage after it advances.
   assign adv_out = !rsp_valid || rsp_ready;
   assign adv_law = !drive_valid || adv_out;
   assign adv_in  = !in_valid_ff || adv_law;
   assign req_ready = adv_in;

   assign law_ctl.load      = adv_law;
   assign law_ctl.src_valid = in_valid_ff;
   assign out_ctl.load      = adv_out;
   assign out_ctl.src_valid = drive_valid;

   // Decode gain writes; the unused index drops the word.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= psr_pkg::PROP_GAIN_RESET;
         integ_gain_ff <= psr_pkg::INTEG_GAIN_RESET;
         deriv_gain_ff <= psr_pkg::DERIV_GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (psr_pkg::csr_index_type'(csr_index))
            psr_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            psr_pkg::CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            psr_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv_in) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         meas_ff <= req_measured;
         tgt_ff  <= req_target;
      end
   end

   psr_law #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_law (
      .clock       (clock),
      .reset       (reset),
      .ctl         (law_ctl),
      .measured    (meas_ff),
      .target      (tgt_ff),
      .prop_gain   (prop_gain_ff),
      .integ_gain  (integ_gain_ff),
      .deriv_gain  (deriv_gain_ff),
      .drive_valid (drive_valid),
      .drive_level (drive_level)
   );

   psr_scale #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PWM_BITS    (PWM_BITS)
   ) u_scale (
      .clock           (clock),
      .reset           (reset),
      .ctl             (out_ctl),
      .drive_level     (drive_level),
      .rsp_valid       (rsp_valid),
      .rsp_drive_level (rsp_drive_level),
      .rsp_pwm_duty    (rsp_pwm_duty)
   );

   // A word leaving the input stage must land in the control-law stage.
   `PSR_ASSERT(a_law_fill, (in_valid_ff && adv_law) |=> drive_valid)
   // A control-law word blocked downstream must hold its value.
   `PSR_ASSERT(a_law_hold, (drive_valid && !adv_law) |=> $stable(drive_level))
   // Full-scale drive maps to full-scale duty, zero to zero.
   `PSR_ASSERT(a_duty_top, (rsp_valid && (&rsp_drive_level)) |-> (&rsp_pwm_duty))
   `PSR_ASSERT_NEVER(a_duty_zero, rsp_valid && (rsp_drive_level == '0) && (rsp_pwm_duty != '0))

endmodule

FILE: rtl/psr_law.sv
`timescale 1ns / 1ps

module psr_law #(
   parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psr_pkg::stage_ctl_type         ctl,
   input  logic [SAMPLE_BITS-1:0]         measured,
   input  logic [SAMPLE_BITS-1:0]         target,
   input  logic [psr_pkg::GAIN_W-1:0]     prop_gain,
   input  logic [psr_pkg::GAIN_W-1:0]     integ_gain,
   input  logic [psr_pkg::GAIN_W-1:0]     deriv_gain,
   output logic                           drive_valid,
   output logic [SAMPLE_BITS-1:0]         drive_level
);

   localparam int N     = SAMPLE_BITS;
   localparam int G     = psr_pkg::GAIN_W;
   localparam int FRAC  = psr_pkg::FRAC_BITS;
   localparam int PRD_W = N + G + 2;
   localparam int ACC_W = N + G + 3;

   logic                   valid_ff;
   logic [N-1:0]           drive_ff;
   logic [N-1:0]           drive_in;
   logic [N-1:0]           integral_ff;
   logic [N-1:0]           integral_in;
   logic [N-1:0]           prev_ff;

   logic signed [N:0]      err;
   logic signed [N:0]      dmeas;
   logic signed [N+1:0]    integ_sum;
   logic signed [PRD_W-1:0] p_prod;
   logic signed [PRD_W-1:0] d_prod;
   logic [N+G-1:0]         i_prod;
   logic signed [ACC_W-1:0] acc;

   assign err   = $signed({1'b0, target}) - $signed({1'b0, measured});
   assign dmeas = $signed({1'b0, measured}) - $signed({1'b0, prev_ff});

   // saturate the running error sum at both rails
   assign integ_sum = $signed({2'b00, integral_ff}) + $signed({err[N], err});

   always_comb begin
      if (integ_sum[N+1]) begin
         integral_in = '0;
      end else if (integ_sum[N]) begin
         integral_in = '1;
      end else begin
         integral_in = integ_sum[N-1:0];
      end
   end

   assign p_prod = $signed({1'b0, prop_gain}) * err;
   assign d_prod = $signed({1'b0, deriv_gain}) * dmeas;
   assign i_prod = integ_gain * integral_in;

   assign acc = ACC_W'(p_prod) + $signed({3'b000, i_prod}) - ACC_W'(d_prod);

   // drop the fraction, then clamp to the sample range
   always_comb begin
      if (acc[ACC_W-1]) begin
         drive_in = '0;
      end else if (|acc[ACC_W-2:FRAC+N]) begin
         drive_in = '1;
      end else begin
         drive_in = acc[FRAC+N-1:FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         integral_ff <= '0;
         prev_ff     <= '0;
      end else if (ctl.load) begin
         valid_ff <= ctl.src_valid;
         if (ctl.src_valid) begin
            integral_ff <= integral_in;
            prev_ff     <= measured;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && ctl.src_valid) begin
         drive_ff <= drive_in;
      end
   end

   assign drive_valid = valid_ff;
   assign drive_level = drive_ff;

endmodule

FILE: rtl/psr_scale.sv
`timescale 1ns / 1ps

module psr_scale #(
   parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF,
   parameter int PWM_BITS    = psr_pkg::PWM_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psr_pkg::stage_ctl_type  ctl,
   input  logic [SAMPLE_BITS-1:0]  drive_level,
   output logic                    rsp_valid,
   output logic [SAMPLE_BITS-1:0]  rsp_drive_level,
   output logic [PWM_BITS-1:0]     rsp_pwm_duty
);

   localparam int N   = SAMPLE_BITS;
   localparam int P   = PWM_BITS;
   localparam int P_W = N + P;
   localparam int T_W = N + P + 1;
   localparam logic [T_W-1:0] D_MAX = T_W'((1 << N) - 1);

   logic               valid_ff;
   logic [N-1:0]       drive_ff;
   logic [P-1:0]       duty_ff;
   logic [P-1:0]       duty_in;

   logic [P_W-1:0]     prod;
   logic [T_W-1:0]     approx;
   logic [P:0]         q_est;
   logic [T_W-1:0]     rem;
   logic [P:0]         q_fix;

   // drive * (2^P - 1) as a shift and subtract
   assign prod = {drive_level, {P{1'b0}}} - P_W'(drive_level);

   // divide by 2^N - 1 through its series; the estimate is low by at most one
   assign approx = T_W'(prod) + T_W'(prod >> N) + T_W'(prod >> (2 * N));
   assign q_est  = approx[T_W-1:N];
   assign rem    = T_W'(prod) - (T_W'(q_est) << N) + T_W'(q_est);
   assign q_fix  = (rem >= D_MAX) ? (q_est + (P+1)'(1)) : q_est;
   assign duty_in = q_fix[P-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && ctl.src_valid) begin
         drive_ff <= drive_level;
         duty_ff  <= duty_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_drive_level = drive_ff;
   assign rsp_pwm_duty    = duty_ff;

endmodule

FILE: dv/pid_speed_regulator_unit_test.sv
`timescale 1ns / 1ps

module pid_speed_regulator_unit_test;

   localparam int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF;
   localparam int PWM_BITS    = psr_pkg::PWM_BITS_DEF;
   localparam longint SAMPLE_MAX = (longint'(1) << SAMPLE_BITS) - 1;
   localparam longint PWM_MAX    = (longint'(1) << PWM_BITS) - 1;

   // The gain register file decodes three indexes; the fourth must do nothing.
   localparam logic [psr_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Three pipeline stages; give the block a little more before touching gains.
   localparam int PIPE_LATENCY   = 3;
   localparam int SETTLE_CYCLES  = PIPE_LATENCY + 2;
   // Longest legal quiet stretch is a sender gap plus a receiver stall; allow
   // far more than that before declaring the block hung.
   localparam int HANG_LIMIT     = 2000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_SAMPLES  = 100;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] drive_level;
      logic [PWM_BITS-1:0]    pwm_duty;
   } drive_word_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_BURSTY
   } ready_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_measured;
   logic [SAMPLE_BITS-1:0] req_target;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SAMPLE_BITS-1:0] rsp_drive_level;
   logic [PWM_BITS-1:0]    rsp_pwm_duty;
   logic                   csr_write_en;
   logic [psr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [psr_pkg::GAIN_W-1:0]      csr_wdata;

   // Shadow copy of the regulator: gains plus the two words of loop state.
   logic [psr_pkg::GAIN_W-1:0] shadow_prop_gain;
   logic [psr_pkg::GAIN_W-1:0] shadow_integ_gain;
   logic [psr_pkg::GAIN_W-1:0] shadow_deriv_gain;
   logic [SAMPLE_BITS-1:0]     shadow_integral;
   logic [SAMPLE_BITS-1:0]     shadow_last_measure;

   drive_word_type pending_drive_q[$];
   int             mismatch_count;
   int             quiet_cycles;

   // Sender burst bookkeeping and the setpoint the tracking stimulus follows.
   int                     burst_left;
   logic [SAMPLE_BITS-1:0] held_target;

   // Receiver stall pattern state.
   ready_mode_type ready_mode;
   int             ready_mode_left;
   int             stall_left;

   pid_speed_regulator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_measured    (req_measured),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_level (rsp_drive_level),
      .rsp_pwm_duty    (rsp_pwm_duty),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor: one control-law step on the shadow state. Gains are Q8.8, so
   // the accumulator carries eight fraction bits; a negative sum drives zero.
   // ------------------------------------------------------------------------
   function automatic drive_word_type regulate_sample(
      input logic [SAMPLE_BITS-1:0] measured,
      input logic [SAMPLE_BITS-1:0] target
   );
      longint         error;
      longint         slope;
      longint         integ;
      longint         acc;
      longint         drive;
      longint         duty;
      drive_word_type word;
      error = longint'(target) - longint'(measured);
      slope = longint'(measured) - longint'(shadow_last_measure);
      // Clamp the running error sum to the sample range at both ends.
      integ = longint'(shadow_integral) + error;
      if (integ < 0) begin
         integ = 0;
      end else if (integ > SAMPLE_MAX) begin
         integ = SAMPLE_MAX;
      end
      acc = longint'(shadow_prop_gain) * error
          + longint'(shadow_integ_gain) * integ
          - longint'(shadow_deriv_gain) * slope;
      if (acc < 0) begin
         drive = 0;
      end else begin
         drive = acc >>> psr_pkg::FRAC_BITS;
         if (drive > SAMPLE_MAX) begin
            drive = SAMPLE_MAX;
         end
      end
      duty = (drive * PWM_MAX) / SAMPLE_MAX;
      shadow_integral     = integ[SAMPLE_BITS-1:0];
      shadow_last_measure = measured;
      word.drive_level    = drive[SAMPLE_BITS-1:0];
      word.pwm_duty       = duty[PWM_BITS-1:0];
      return word;
   endfunction

   // ------------------------------------------------------------------------
   // Gain writes: one cycle of write enable, mirrored into the shadow copy.
   // Only call these with the pipeline empty.
   // ------------------------------------------------------------------------
   task automatic write_gain(input logic [psr_pkg::CSR_INDEX_W-1:0] index,
                             input logic [psr_pkg::GAIN_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         psr_pkg::CSR_PROP_GAIN: begin
            shadow_prop_gain = value;
         end
         psr_pkg::CSR_INTEG_GAIN: begin
            shadow_integ_gain = value;
         end
         psr_pkg::CSR_DERIV_GAIN: begin
            shadow_deriv_gain = value;
         end
         default: begin
            // undecoded index: the block drops the write
         end
      endcase
   endtask

   task automatic write_gains(input logic [psr_pkg::GAIN_W-1:0] prop,
                              input logic [psr_pkg::GAIN_W-1:0] integ,
                              input logic [psr_pkg::GAIN_W-1:0] deriv);
      write_gain(psr_pkg::CSR_PROP_GAIN, prop);
      write_gain(psr_pkg::CSR_INTEG_GAIN, integ);
      write_gain(psr_pkg::CSR_DERIV_GAIN, deriv);
   endtask

   // ------------------------------------------------------------------------
   // Send one sample word. The sender runs in bursts: at the start of each
   // burst drop valid for a random gap (possibly none), then keep valid high
   // across the burst, changing only the payload after each accept. Return
   // at the rising edge that accepted the word.
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] measured,
                              input logic [SAMPLE_BITS-1:0] target);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         // a fifth of the bursts are long and back to back, to hold full rate
         if ($urandom_range(0, 4) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(20, 60);
         end else begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_measured <= measured;
      req_target   <= target;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_drive_q.push_back(regulate_sample(measured, target));
   endtask

   // Drop valid, wait for every expected word, then let the pipe go quiet.
   task automatic drain_pipeline;
      @(negedge clock);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_drive_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Random stimulus picks. Most samples track a held setpoint with a small
   // measurement offset, the way a closed loop sees them; the rest are fully
   // random or pinned to the ends of the range.
   // ------------------------------------------------------------------------
   function automatic logic [SAMPLE_BITS-1:0] edge_or_random_sample;
      case ($urandom_range(0, 2))
         0: return '0;
         1: return SAMPLE_MAX[SAMPLE_BITS-1:0];
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic pick_sample(output logic [SAMPLE_BITS-1:0] measured,
                              output logic [SAMPLE_BITS-1:0] target);
      int     kind;
      longint offset_meas;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) begin
         held_target = SAMPLE_BITS'($urandom);
      end
      if (kind <= 5) begin
         offset_meas = longint'(held_target) + $urandom_range(0, 96) - 48;
         if (offset_meas < 0) begin
            offset_meas = 0;
         end else if (offset_meas > SAMPLE_MAX) begin
            offset_meas = SAMPLE_MAX;
         end
         measured = offset_meas[SAMPLE_BITS-1:0];
         target   = held_target;
      end else if (kind <= 7) begin
         measured = SAMPLE_BITS'($urandom);
         target   = SAMPLE_BITS'($urandom);
      end else begin
         measured = edge_or_random_sample();
         target   = edge_or_random_sample();
      end
   endtask

   function automatic logic [psr_pkg::GAIN_W-1:0] pick_gain;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return psr_pkg::GAIN_W'($urandom);
         // gains up to 32.0 keep the output off the rails most of the time
         default: return psr_pkg::GAIN_W'($urandom_range(0, 8191));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Leave the proportional gain at its reset value and set only a derivative
   // gain of 1.0: the first sample sees its whole measurement as a change.
   task automatic test_first_sample_after_reset;
      write_gain(psr_pkg::CSR_DERIV_GAIN, 16'h0100);
      send_sample(10'd40, 10'd60);
      send_sample(10'd40, 10'd60);
      send_sample(10'd100, 10'd90);
      drain_pipeline();
   endtask

   // Each gain alone at zero and at full scale, with samples at the rails:
   // saturation high, negative sums, and the derivative kick in both signs.
   task automatic test_gain_extremes;
      write_gains('0, '0, '0);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd0, 10'd1023);
      drain_pipeline();
      write_gains('1, '0, '0);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd512, 10'd512);
      drain_pipeline();
      write_gains('0, '1, '0);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd0);
      drain_pipeline();
      write_gains('0, '0, '1);
      send_sample(10'd0, 10'd0);
      send_sample(10'd1023, 10'd1023);
      drain_pipeline();
   endtask

   // Integral-only loop: push the sum past the top, then past the bottom.
   task automatic test_integral_saturation;
      write_gains('0, 16'h0100, '0);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd500, 10'd510);
      drain_pipeline();
   endtask

   // A write to the undecoded index must leave all three gains alone.
   task automatic test_unused_index;
      write_gains(psr_pkg::PROP_GAIN_RESET, 16'h0040, 16'h0080);
      write_gain(CSR_UNUSED_INDEX, '1);
      send_sample(10'd300, 10'd700);
      send_sample(10'd700, 10'd300);
      drain_pipeline();
   endtask

   // Several gain settings, each followed by a run of random samples. The
   // first phase uses a plausible tuned loop; the others draw gains at random.
   task automatic test_random_regulation;
      logic [SAMPLE_BITS-1:0] measured;
      logic [SAMPLE_BITS-1:0] target;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_gains(psr_pkg::PROP_GAIN_RESET, 16'd26, 16'd32);
         end else begin
            write_gains(pick_gain(), pick_gain(), pick_gain());
         end
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            pick_sample(measured, target);
            send_sample(measured, target);
         end
         drain_pipeline();
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: switch among always-ready, random ready and long stalls so the
   // back-pressure lands on every stage of the pipe.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 2));
         ready_mode_left = $urandom_range(20, 120);
      end
      ready_mode_left--;
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
               stall_left = $urandom_range(1, 15);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Checker: compare each accepted response word with the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive_q.size() == 0) begin
            $error("unexpected response word: drive_level %0d pwm_duty %0d",
                   rsp_drive_level, rsp_pwm_duty);
            mismatch_count++;
         end else begin
            want = pending_drive_q.pop_front();
            if (rsp_drive_level !== want.drive_level) begin
               $error("drive_level: expected %0d, actual %0d",
                      want.drive_level, rsp_drive_level);
               mismatch_count++;
            end
            if (rsp_pwm_duty !== want.pwm_duty) begin
               $error("pwm_duty: expected %0d, actual %0d",
                      want.pwm_duty, rsp_pwm_duty);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Hold every input at a known value from time zero.
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_measured    = '0;
      req_target      = '0;
      rsp_ready       = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = psr_pkg::CSR_PROP_GAIN;
      csr_wdata       = '0;
      mismatch_count  = 0;
      quiet_cycles    = 0;
      burst_left      = 0;
      held_target     = 10'd512;
      ready_mode      = READY_ALWAYS;
      ready_mode_left = 0;
      stall_left      = 0;

      // Shadow state matches the block just out of reset.
      shadow_prop_gain    = psr_pkg::PROP_GAIN_RESET;
      shadow_integ_gain   = psr_pkg::INTEG_GAIN_RESET;
      shadow_deriv_gain   = psr_pkg::DERIV_GAIN_RESET;
      shadow_integral     = '0;
      shadow_last_measure = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_sample_after_reset();
      test_gain_extremes();
      test_integral_saturation();
      test_unused_index();
      test_random_regulation();

      // Allow for any stray word the block might still emit.
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && pending_drive_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
